FILE: design/point_in_polygon_set_filter_assert.svh
// ----------------------------------------------------------------------------
// Point-in-polygon set filter assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_SET_FILTER_ASSERT_SVH
`define POINT_IN_POLYGON_SET_FILTER_ASSERT_SVH

// A condition that holds at the same clock edge as its trigger.
`define PIPSF_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// A condition that holds at the clock edge after its trigger.
`define PIPSF_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/pipsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter package
// Field widths, default sizes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pipsf_pkg;

	localparam int DEF_MAX_POLYGONS = 16;
	localparam int DEF_MAX_VERTICES = 4;

	localparam int POLY_IDX_W = 4;
	localparam int VTX_IDX_W  = 2;
	localparam int LAT_W      = 28;
	localparam int LON_W      = 29;
	localparam int CFG_W      = 5;
	localparam int MATCH_W    = 4;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 8;

	localparam int DLAT_W = LAT_W + 1;
	localparam int DLON_W = LON_W + 1;
	localparam int PROD_W = DLAT_W + DLON_W;

	typedef struct packed {
		logic start;
		logic load_wr;
		logic issue;
		logic is_edge;
		logic is_last;
		logic load_result;
	} pipsf_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_busy;
	} pipsf_status_t;

endpackage

FILE: design/point_in_polygon_set_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter
// Tests a point against a table of small polygons with the even-odd rule and
// reports the first polygon that contains it.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel. A transfer with tuser low writes one
// vertex into the polygon table, and tlast high also sets that polygon's
// vertex count; while the block is idle, loads are taken one per cycle and
// may follow back to back. A transfer with tuser high queries a point; the
// block then accepts nothing until its result has been moved to the output
// register. A query reads one vertex per cycle from the single read port of
// the vertex memory: each polygon is read as its last vertex and then all its
// vertices in order, and an empty slot is skipped without a read. The
// pipeline then drains and the result register is loaded, after which the
// next item can be taken.
// The result waits in a register on the m_axis channel while the block takes
// further loads; a second result waits inside until the receiver takes the
// first. cfg_wr_en writes the polygon count at once; use it only while the
// block is idle, which the block does not check. Reset clears the polygon
// count and all vertex counts; coordinates keep what they held until written.
// ----------------------------------------------------------------------------
module point_in_polygon_set_filter
	import pipsf_pkg::*;
#(
	parameter int MAX_POLYGONS = DEF_MAX_POLYGONS,
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// poly_index, vertex_index, coord_lat, coord_lon, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                  s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// inside_res, match_index, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int PIW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
	localparam int VIW = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);

	localparam int VIDX_LO = POLY_IDX_W;
	localparam int LAT_LO  = VIDX_LO + VTX_IDX_W;
	localparam int LON_LO  = LAT_LO + LAT_W;

	pipsf_cmd_t     cmd;
	pipsf_status_t  status;
	logic [PIW-1:0] poly_sel;
	logic [VIW-1:0] vtx_sel;
	logic [CW-1:0]  cur_count;

	logic [POLY_IDX_W-1:0]   poly_index;
	logic [VTX_IDX_W-1:0]    vertex_index;
	logic signed [LAT_W-1:0] coord_lat;
	logic signed [LON_W-1:0] coord_lon;

	assign poly_index   = s_axis_tdata[POLY_IDX_W-1:0];
	assign vertex_index = s_axis_tdata[LAT_LO-1:VIDX_LO];
	assign coord_lat    = s_axis_tdata[LON_LO-1:LAT_LO];
	assign coord_lon    = s_axis_tdata[LON_LO+LON_W-1:LON_LO];

	pipsf_ctrl #(
		.MAX_POLYGONS (MAX_POLYGONS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.kind          (s_axis_tuser),
		.cur_count     (cur_count),
		.status        (status),
		.cmd           (cmd),
		.poly_sel      (poly_sel),
		.vtx_sel       (vtx_sel)
	);

	pipsf_datapath #(
		.MAX_POLYGONS (MAX_POLYGONS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.poly_sel      (poly_sel),
		.vtx_sel       (vtx_sel),
		.poly_index    (poly_index),
		.vertex_index  (vertex_index),
		.vertex_last   (s_axis_tlast),
		.coord_lat     (coord_lat),
		.coord_lon     (coord_lon),
		.cur_count     (cur_count),
		.status        (status),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

FILE: design/pipsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter controller
// Holds the polygon count register and sequences the vertex reads of a query,
// one read per cycle, then waits for the datapath to drain.
// ----------------------------------------------------------------------------
module pipsf_ctrl
	import pipsf_pkg::*;
#(
	parameter int MAX_POLYGONS = DEF_MAX_POLYGONS,
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	localparam int PIW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
	localparam int PCW = $clog2(MAX_POLYGONS + 1),
	localparam int VIW = $clog2(MAX_VERTICES),
	localparam int CW  = $clog2(MAX_VERTICES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic              kind,
	input  logic [CW-1:0]     cur_count,
	input  pipsf_status_t     status,
	output pipsf_cmd_t        cmd,
	output logic [PIW-1:0]    poly_sel,
	output logic [VIW-1:0]    vtx_sel
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ISSUE  = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] polygon_count_q;
	logic [PCW-1:0]   poly_q;
	logic [CW-1:0]    step_q;
	logic [PCW-1:0]   limit;
	logic             in_acc;
	logic             poly_done;
	logic             empty_poly;
	logic             step_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (int'(polygon_count_q) > MAX_POLYGONS) begin
			limit = PCW'(MAX_POLYGONS);
		end else begin
			limit = PCW'(polygon_count_q);
		end
	end

	assign poly_sel   = poly_q[PIW-1:0];
	assign poly_done  = (poly_q >= limit);
	assign empty_poly = (cur_count == '0);
	assign step_last  = (step_q == cur_count);

	always_comb begin
		if (step_q == '0) begin
			vtx_sel = VIW'(cur_count - CW'(1));
		end else begin
			vtx_sel = VIW'(step_q - CW'(1));
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.start       = in_acc && kind;
		cmd.load_wr     = in_acc && !kind;
		cmd.issue       = (state_q == ST_ISSUE) && !poly_done && !empty_poly;
		cmd.is_edge     = (step_q != '0);
		cmd.is_last     = (step_q != '0) && step_last;
		cmd.load_result = (state_q == ST_RESULT) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polygon_count_q <= '0;
		end else if (cfg_wr_en) begin
			polygon_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			poly_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						poly_q  <= '0;
						step_q  <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (poly_done) begin
						state_q <= ST_DRAIN;
					end else if (empty_poly) begin
						poly_q <= poly_q + PCW'(1);
					end else if (step_q != '0 && step_last) begin
						step_q <= '0;
						poly_q <= poly_q + PCW'(1);
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/pipsf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter datapath
// Vertex memories, vertex count table, the three-stage edge crossing pipeline
// with its even-odd parity, and the result register.
// ----------------------------------------------------------------------------
module pipsf_datapath
	import pipsf_pkg::*;
#(
	parameter int MAX_POLYGONS = DEF_MAX_POLYGONS,
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	localparam int PIW   = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
	localparam int VIW   = $clog2(MAX_VERTICES),
	localparam int CW    = $clog2(MAX_VERTICES + 1),
	localparam int DEPTH = MAX_POLYGONS * MAX_VERTICES,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pipsf_cmd_t             cmd,
	input  logic [PIW-1:0]         poly_sel,
	input  logic [VIW-1:0]         vtx_sel,
	input  logic [POLY_IDX_W-1:0]  poly_index,
	input  logic [VTX_IDX_W-1:0]   vertex_index,
	input  logic                   vertex_last,
	input  logic signed [LAT_W-1:0] coord_lat,
	input  logic signed [LON_W-1:0] coord_lon,
	output logic [CW-1:0]          cur_count,
	output pipsf_status_t          status,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

	logic signed [LAT_W-1:0] lat_mem [DEPTH];
	logic signed [LON_W-1:0] lon_mem [DEPTH];
	logic [CW-1:0]           count_q [MAX_POLYGONS];

	logic                    load_ok;
	logic [PIW-1:0]          load_poly;
	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;

	logic signed [LAT_W-1:0] pt_lat_q;
	logic signed [LON_W-1:0] pt_lon_q;
	logic signed [LAT_W-1:0] prev_lat_q;
	logic signed [LON_W-1:0] prev_lon_q;

	logic                    v_s1, v_s2, v_s3;
	logic                    edge_s1, edge_s2, edge_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [PIW-1:0]          poly_s1, poly_s2, poly_s3;
	logic signed [LAT_W-1:0] lat_s1;
	logic signed [LON_W-1:0] lon_s1;
	logic                    cross_s2, cross_s3;
	logic                    dypos_s2, dypos_s3;
	logic signed [DLON_W-1:0] dlon_s2;
	logic signed [DLAT_W-1:0] dy_s2;
	logic signed [DLAT_W-1:0] dlat_s2;
	logic signed [DLON_W-1:0] dx_s2;
	logic signed [PROD_W-1:0] lhs_s3;
	logic signed [PROD_W-1:0] rhs_s3;

	logic                    left_side;
	logic                    parity_next;
	logic                    parity_q;
	logic                    found_q;
	logic [PIW-1:0]          match_q;
	logic                    out_valid_q;
	logic                    out_inside_q;
	logic [MATCH_W-1:0]      out_match_q;

	assign load_ok   = (int'(poly_index) < MAX_POLYGONS) && (int'(vertex_index) < MAX_VERTICES);
	assign load_poly = PIW'(poly_index);
	assign wr_addr   = AW'(load_poly) * AW'(MAX_VERTICES) + AW'(vertex_index);
	assign rd_addr   = AW'(poly_sel) * AW'(MAX_VERTICES) + AW'(vtx_sel);
	assign cur_count = count_q[poly_sel];

	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_ok) begin
			lat_mem[wr_addr] <= coord_lat;
			lon_mem[wr_addr] <= coord_lon;
		end
		if (cmd.issue) begin
			lat_s1 <= lat_mem[rd_addr];
			lon_s1 <= lon_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_POLYGONS; k++) begin
				count_q[k] <= '0;
			end
		end else if (cmd.load_wr && load_ok && vertex_last) begin
			count_q[load_poly] <= CW'({1'b0, vertex_index} + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pt_lat_q <= coord_lat;
			pt_lon_q <= coord_lon;
		end
		edge_s1 <= cmd.is_edge;
		last_s1 <= cmd.is_last;
		poly_s1 <= poly_sel;
		if (v_s1) begin
			prev_lat_q <= lat_s1;
			prev_lon_q <= lon_s1;
		end
		edge_s2  <= edge_s1;
		last_s2  <= last_s1;
		poly_s2  <= poly_s1;
		cross_s2 <= (lat_s1 > pt_lat_q) != (prev_lat_q > pt_lat_q);
		dypos_s2 <= prev_lat_q > lat_s1;
		dlon_s2  <= DLON_W'(pt_lon_q) - DLON_W'(lon_s1);
		dy_s2    <= DLAT_W'(prev_lat_q) - DLAT_W'(lat_s1);
		dlat_s2  <= DLAT_W'(pt_lat_q) - DLAT_W'(lat_s1);
		dx_s2    <= DLON_W'(prev_lon_q) - DLON_W'(lon_s1);
		edge_s3  <= edge_s2;
		last_s3  <= last_s2;
		poly_s3  <= poly_s2;
		cross_s3 <= cross_s2;
		dypos_s3 <= dypos_s2;
		lhs_s3   <= PROD_W'(dlon_s2) * PROD_W'(dy_s2);
		rhs_s3   <= PROD_W'(dlat_s2) * PROD_W'(dx_s2);
	end

	assign left_side   = dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3);
	assign parity_next = parity_q ^ (cross_s3 && left_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			parity_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (v_s3) begin
				if (!edge_s3) begin
					parity_q <= 1'b0;
				end else begin
					parity_q <= parity_next;
					if (last_s3 && parity_next && !found_q) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && edge_s3 && last_s3 && parity_next && !found_q) begin
			match_q <= poly_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_inside_q <= found_q;
			out_match_q  <= found_q ? MATCH_W'(match_q) : '0;
		end
	end

	assign status.pipe_busy = v_s1 || v_s2 || v_s3;
	assign status.out_busy  = out_valid_q && !m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - MATCH_W - 1){1'b0}}, out_match_q, out_inside_q};

endmodule

FILE: design/pipsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter port checker
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
`include "point_in_polygon_set_filter_assert.svh"

module pipsf_checker
	import pipsf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	`PIPSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed or vanished while stalled")
	`PIPSF_ASSERT_SAME(a_no_match_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[MATCH_W:1] == '0, "match index not zero without a hit")
	`PIPSF_ASSERT_NEXT(a_load_no_result, in_xfer && !s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "a vertex load produced a result")
	`PIPSF_ASSERT_NEXT(a_query_busy, in_xfer && s_axis_tuser, !s_axis_tready, "input taken while a query is in progress")

endmodule

bind point_in_polygon_set_filter pipsf_checker u_pipsf_checker (.*);

FILE: sim/tb_point_in_polygon_set_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon set filter testbench
// Loads polygon vertices and queries points over the stream channels, with
// bursty input and a stalling receiver. Each result is compared with a value
// from the directed list or a local even-odd ray-casting predictor that tracks
// the polygon table and the polygon count, across several count settings.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_set_filter;
	import pipsf_pkg::*;

	localparam int NUM_SLOTS    = DEF_MAX_POLYGONS;
	localparam int NUM_VERTS    = DEF_MAX_VERTICES;
	localparam int LAT_MAX      = 90000000;
	localparam int LON_MAX      = 180000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 190;

	localparam int VIDX_LSB = POLY_IDX_W;
	localparam int LAT_LSB  = VIDX_LSB + VTX_IDX_W;
	localparam int LON_LSB  = LAT_LSB + LAT_W;

	localparam bit KIND_LOAD  = 1'b0;
	localparam bit KIND_QUERY = 1'b1;

	typedef enum {ROW_LOAD, ROW_QUERY, ROW_CONFIG} row_op_t;

	typedef struct packed {
		logic               hit;
		logic [MATCH_W-1:0] slot;
	} match_t;

	typedef struct {
		row_op_t op;
		int      slot;
		int      vidx;
		bit      last;
		int      lat;
		int      lon;
		int      setting;
		bit      typed;
		match_t  want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Polygon table as the block should hold it.
	longint vtx_lat[NUM_SLOTS][NUM_VERTS];
	longint vtx_lon[NUM_SLOTS][NUM_VERTS];
	bit     vtx_written[NUM_SLOTS][NUM_VERTS];
	int     vtx_count[NUM_SLOTS];
	int     poly_limit = 0;

	match_t   expected_matches[$];
	dir_row_t dir_rows[$];

	int fail_count = 0;
	int load_total = 0;
	int query_total = 0;
	int hit_total = 0;
	int setting_total = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int cycle_count = 0;

	point_in_polygon_set_filter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_point_in_polygon_set_filter failed");
			$finish;
		end
	end

	function automatic int srand(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int clip(longint v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	// Even-odd rule with the crossing test cross-multiplied, so the sense of
	// the comparison follows the sign of the edge's latitude span.
	function automatic bit poly_holds(int p, longint lat, longint lon);
		int     n;
		int     j;
		bit     odd;
		longint xi, yi, xj, yj, dy, lhs, rhs;
		n = vtx_count[p];
		odd = 1'b0;
		if (n == 0) return 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = vtx_lon[p][i];
			yi = vtx_lat[p][i];
			xj = vtx_lon[p][j];
			yj = vtx_lat[p][j];
			if ((yi > lat) != (yj > lat)) begin
				dy = yj - yi;
				lhs = (lon - xi) * dy;
				rhs = (lat - yi) * (xj - xi);
				if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = !odd;
			end
			j = i;
		end
		return odd;
	endfunction

	function automatic match_t locate_point(longint lat, longint lon);
		int     top;
		match_t m;
		m = '0;
		top = (poly_limit > NUM_SLOTS) ? NUM_SLOTS : poly_limit;
		for (int p = 0; p < top; p++) begin
			if (poly_holds(p, lat, lon)) begin
				m.hit = 1'b1;
				m.slot = MATCH_W'(p);
				return m;
			end
		end
		return m;
	endfunction

	function automatic dir_row_t ld(int slot, int vidx, bit last, int lat, int lon);
		dir_row_t r;
		r = '{ROW_LOAD, slot, vidx, last, lat, lon, 0, 1'b0, '0};
		return r;
	endfunction

	function automatic dir_row_t qr(int lat, int lon);
		dir_row_t r;
		r = '{ROW_QUERY, 0, 0, 1'b0, lat, lon, 0, 1'b0, '0};
		return r;
	endfunction

	function automatic dir_row_t qt(int lat, int lon, bit hit, int slot);
		dir_row_t r;
		r = '{ROW_QUERY, 0, 0, 1'b0, lat, lon, 0, 1'b1, '0};
		r.want.hit = hit;
		r.want.slot = MATCH_W'(slot);
		return r;
	endfunction

	function automatic dir_row_t cf(int setting);
		dir_row_t r;
		r = '{ROW_CONFIG, 0, 0, 1'b0, 0, 0, setting, 1'b0, '0};
		return r;
	endfunction

	// Drives one item, holds it until the transfer, then updates the
	// predicted table or queues the predicted match.
	task automatic send_item(input bit kind, input int slot, input int vidx, input bit last,
			input int lat, input int lon, input bit typed, input match_t want);
		logic [IN_DATA_W-1:0] word;
		int                   gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 12);
		end
		word = '0;
		word[POLY_IDX_W-1:0] = slot[POLY_IDX_W-1:0];
		word[LAT_LSB-1:VIDX_LSB] = vidx[VTX_IDX_W-1:0];
		word[LON_LSB-1:LAT_LSB] = lat[LAT_W-1:0];
		word[LON_LSB+LON_W-1:LON_LSB] = lon[LON_W-1:0];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= kind;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (burst_left == 0) s_axis_tvalid <= 1'b0;
		if (kind == KIND_LOAD) begin
			vtx_lat[slot][vidx] = lat;
			vtx_lon[slot][vidx] = lon;
			vtx_written[slot][vidx] = 1'b1;
			if (last) vtx_count[slot] = vidx + 1;
			load_total++;
		end else begin
			expected_matches.push_back(typed ? want : locate_point(lat, lon));
			query_total++;
		end
	endtask

	task automatic end_burst();
		if (burst_left != 0) begin
			burst_left = 0;
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		end_burst();
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input int setting);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= setting[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		poly_limit = setting;
		setting_total++;
	endtask

	// Mostly whole polygons and queries near their vertices, with stray
	// vertex writes and cut-off polygon loads mixed in.
	task automatic run_phase(input int n_items);
		int stop, r, slot, n, span, clat, clon, off, a, b, jit, k, qlat, qlon, vidx;
		bit last;
		int plat[NUM_VERTS];
		int plon[NUM_VERTS];
		stop = load_total + query_total + n_items;
		while (load_total + query_total < stop) begin
			r = $urandom_range(0, 99);
			slot = $urandom_range(0, NUM_SLOTS - 1);
			if (r < 20) begin
				k = $urandom_range(0, 99);
				n = (k < 10) ? 1 : (k < 20) ? 2 : (k < 45) ? 3 : 4;
				case ($urandom_range(0, 2))
					0: begin
						span = $urandom_range(1, 200);
					end
					1: begin
						span = $urandom_range(200, 200000);
					end
					default: begin
						span = $urandom_range(200000, 60000000);
					end
				endcase
				clat = srand(LAT_MAX);
				clon = srand(LON_MAX);
				for (int v = 0; v < NUM_VERTS; v++) begin
					if ($urandom_range(0, 6) == 0) begin
						plat[v] = srand(LAT_MAX);
						plon[v] = srand(LON_MAX);
					end else begin
						off = int'($urandom_range(1, span));
						plat[v] = clip(longint'(clat) + ((v < 2) ? -off : off), -LAT_MAX, LAT_MAX);
						off = int'($urandom_range(1, span));
						plon[v] = clip(longint'(clon) + ((v == 1 || v == 2) ? off : -off),
							-LON_MAX, LON_MAX);
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					k = $urandom_range(1, n);
					for (int v = 0; v < k; v++)
						send_item(KIND_LOAD, slot, v, 1'b0, plat[v], plon[v], 1'b0, '0);
				end else begin
					for (int v = 0; v < n; v++)
						send_item(KIND_LOAD, slot, v, v == n - 1, plat[v], plon[v], 1'b0, '0);
				end
			end else if (r < 30) begin
				vidx = $urandom_range(0, NUM_VERTS - 1);
				last = 1'b0;
				if ($urandom_range(0, 1) == 1) begin
					last = 1'b1;
					for (int v = 0; v < vidx; v++)
						if (!vtx_written[slot][v]) last = 1'b0;
				end
				send_item(KIND_LOAD, slot, vidx, last, srand(LAT_MAX), srand(LON_MAX), 1'b0, '0);
			end else begin
				n = vtx_count[slot];
				if (n != 0 && $urandom_range(0, 99) < 70) begin
					a = $urandom_range(0, n - 1);
					b = $urandom_range(0, n - 1);
					case ($urandom_range(0, 3))
						0: begin
							jit = 0;
						end
						1: begin
							jit = 3;
						end
						2: begin
							jit = 5000;
						end
						default: begin
							jit = 2000000;
						end
					endcase
					qlat = clip((vtx_lat[slot][a] + vtx_lat[slot][b]) / 2 + srand(jit),
						-LAT_MAX, LAT_MAX);
					qlon = clip((vtx_lon[slot][a] + vtx_lon[slot][b]) / 2 + srand(jit),
						-LON_MAX, LON_MAX);
				end else if ($urandom_range(0, 9) == 0) begin
					qlat = ($urandom_range(0, 1) == 1) ? LAT_MAX : -LAT_MAX;
					qlon = ($urandom_range(0, 1) == 1) ? LON_MAX : -LON_MAX;
				end else begin
					qlat = srand(LAT_MAX);
					qlon = srand(LON_MAX);
				end
				send_item(KIND_QUERY, $urandom_range(0, NUM_SLOTS - 1),
					$urandom_range(0, NUM_VERTS - 1), $urandom_range(0, 1), qlat, qlon, 1'b0, '0);
			end
		end
	endtask

	// Result checking and the receiver's stall pattern.
	always @(posedge clk) begin : result_check
		match_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_matches.size() == 0) begin
					$error("result transfer with no query pending: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_matches.pop_front();
					if (m_axis_tdata[0] !== want.hit) begin
						$error("inside_res: expected %0d, actual %0d", want.hit, m_axis_tdata[0]);
						fail_count++;
					end
					if (m_axis_tdata[MATCH_W:1] !== want.slot) begin
						$error("match_index: expected %0d, actual %0d", want.slot,
							m_axis_tdata[MATCH_W:1]);
						fail_count++;
					end
					if (m_axis_tdata[OUT_DATA_W-1:MATCH_W+1] !== '0) begin
						$error("zero fill: expected 0, actual %0h",
							m_axis_tdata[OUT_DATA_W-1:MATCH_W+1]);
						fail_count++;
					end
				end
				if (m_axis_tdata[0] === 1'b1) hit_total++;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (stall_mode != 0 && $urandom_range(0, 99) < ((stall_mode == 1) ? 10 : 40))
					stall_left = $urandom_range(1, (stall_mode == 1) ? 4 : 30);
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(100, 1500);
			end else begin
				mode_left--;
			end
		end
	end

	initial begin
		dir_row_t row;
		int       rand_limit;

		// The polygon count is still at its reset value for the first queries.
		dir_rows.push_back(qt(LAT_MAX, LON_MAX, 1'b0, 0));
		dir_rows.push_back(qt(-LAT_MAX, -LON_MAX, 1'b0, 0));
		dir_rows.push_back(ld(0, 0, 1'b0, -1000, -1000));
		dir_rows.push_back(ld(0, 1, 1'b0, -1000, 1000));
		dir_rows.push_back(ld(0, 2, 1'b0, 1000, 1000));
		dir_rows.push_back(ld(0, 3, 1'b1, 1000, -1000));
		dir_rows.push_back(ld(1, 0, 1'b0, -LAT_MAX, -LON_MAX));
		dir_rows.push_back(ld(1, 1, 1'b0, -LAT_MAX, LON_MAX));
		dir_rows.push_back(ld(1, 2, 1'b1, LAT_MAX, LON_MAX));
		dir_rows.push_back(ld(2, 0, 1'b1, 5000, 5000));
		dir_rows.push_back(ld(3, 0, 1'b0, 0, 0));
		dir_rows.push_back(ld(3, 1, 1'b1, 7000, 7000));
		// A vertex written without the last flag leaves slot 5 empty.
		dir_rows.push_back(ld(5, 3, 1'b0, 3, 3));
		dir_rows.push_back(cf(NUM_SLOTS));
		dir_rows.push_back(qr(0, 0));
		dir_rows.push_back(qr(2000, 2000));
		dir_rows.push_back(qr(-1000, 0));
		dir_rows.push_back(qr(1000, 0));
		dir_rows.push_back(qr(0, 1000));
		dir_rows.push_back(qr(-LAT_MAX + 1, LON_MAX - 1));
		dir_rows.push_back(qr(LAT_MAX, LON_MAX));
		dir_rows.push_back(cf(31));
		dir_rows.push_back(qr(0, 0));
		dir_rows.push_back(cf(1));
		dir_rows.push_back(qr(0, 0));
		dir_rows.push_back(qr(0, 100000));
		dir_rows.push_back(cf(0));
		dir_rows.push_back(qt(0, 0, 1'b0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			case (row.op)
				ROW_CONFIG: begin
					write_limit(row.setting);
				end
				ROW_LOAD: begin
					send_item(KIND_LOAD, row.slot, row.vidx, row.last, row.lat, row.lon, 1'b0, '0);
				end
				default: begin
					send_item(KIND_QUERY, row.slot, row.vidx, row.last, row.lat, row.lon,
						row.typed, row.want);
				end
			endcase
		end

		rand_limit = $urandom_range(1, NUM_SLOTS - 1);
		write_limit(NUM_SLOTS);
		run_phase(PHASE_ITEMS);
		write_limit(4);
		run_phase(PHASE_ITEMS);
		write_limit(NUM_SLOTS);
		run_phase(PHASE_ITEMS);
		write_limit(31);
		run_phase(PHASE_ITEMS);
		write_limit(0);
		run_phase(PHASE_ITEMS);
		write_limit(rand_limit);
		run_phase(PHASE_ITEMS);
		write_limit(NUM_SLOTS);
		run_phase(PHASE_ITEMS);
		wait_idle();

		$display("Covered %0d vertex loads and %0d point queries, %0d of them inside a polygon.",
			load_total, query_total, hit_total);
		$display("Polygon count was written %0d times, including 0, 16 and 31.", setting_total);
		if (fail_count == 0) begin
			$display("tb_point_in_polygon_set_filter passed");
		end else begin
			$display("tb_point_in_polygon_set_filter failed");
		end
		$finish;
	end

endmodule
